### src/bss_pkg.sv
// ============================================================================
// bss_pkg
// Shared types and constants of the bounded stack with search.
// ============================================================================
package bss_pkg;

    localparam int VALUE_W   = 64;    // port width of value fields
    localparam int CAP_W     = 9;     // capacity register width
    localparam int DIST_W    = 8;     // reported search distance width
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_SEARCH = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    accept;        // item taken: latch search key, clear distance
        logic    push_wr;       // write value at fill count, count up
        logic    pop_dec;       // count down
        logic    rd_top;        // read the top entry
        logic    rd_next;       // read the entry below the current pointer
        logic    res_load;      // load the result register
        t_status res_status;
        logic    res_use_rd;    // result carries the read data
        logic    res_use_dist;  // result carries the search distance
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
        logic hit;              // read data equals search key
        logic last;             // pointer sits on the bottom entry
    } t_sts;

endpackage

### src/bss_if.sv
// ============================================================================
// bss_req_if / bss_rsp_if
// Valid/ready channels for requests and results of the stack.
// ============================================================================
interface bss_req_if;
    import bss_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bss_rsp_if;
    import bss_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [DIST_W-1:0]   distance_from_top;
    logic                is_empty;

    modport source (output valid, output status, output read_value,
                    output distance_from_top, output is_empty, input ready);
    modport sink   (input valid, input status, input read_value,
                    input distance_from_top, input is_empty, output ready);
endinterface

### src/bss_ram.sv
// ============================================================================
// bss_ram
// Simple dual-port RAM, one write and one registered read port.
// ============================================================================
module bss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];   // holds when not reading
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bss_ctrl.sv
// ============================================================================
// bss_ctrl
// Request sequencer: decodes items, drives reads, walks searches.
// ============================================================================
module bss_ctrl
    import bss_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACTION_W-1:0] i_action,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  t_sts                i_sts,
    output t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SRCH = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;
    logic   accept;
    t_cmd   cmd;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && slot_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state          = r_state;
        cmd.accept       = accept;
        cmd.push_wr      = 1'b0;
        cmd.pop_dec      = 1'b0;
        cmd.rd_top       = 1'b0;
        cmd.rd_next      = 1'b0;
        cmd.res_load     = 1'b0;
        cmd.res_status   = ST_OK;
        cmd.res_use_rd   = 1'b0;
        cmd.res_use_dist = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action)) inside
                        ACT_PUSH: begin
                            cmd.res_load = 1'b1;
                            if (i_sts.full) begin
                                cmd.res_status = ST_FULL;
                            end else begin
                                cmd.push_wr = 1'b1;
                            end
                        end
                        ACT_POP, ACT_PEEK: begin
                            if (i_sts.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end else begin
                                cmd.rd_top  = 1'b1;
                                cmd.pop_dec = (t_action'(i_action) == ACT_POP);
                                n_state     = S_READ;
                            end
                        end
                        ACT_SEARCH: begin
                            if (i_sts.empty) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = ST_MISSING;
                            end else begin
                                cmd.rd_top = 1'b1;
                                n_state    = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (slot_free) begin
                    cmd.res_load   = 1'b1;
                    cmd.res_use_rd = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SRCH: begin
                if (i_sts.hit) begin
                    if (slot_free) begin
                        cmd.res_load     = 1'b1;
                        cmd.res_use_dist = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.last) begin
                    if (slot_free) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_MISSING;
                        n_state        = S_IDLE;
                    end
                end else begin
                    cmd.rd_next = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a new result never lands on one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.res_load |-> slot_free)
        else $error("result loaded over a pending result");

    // a search that neither hits nor ends keeps walking
    a_search_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && !i_sts.hit && !i_sts.last) |=> (r_state == S_SRCH))
        else $error("search left before reaching a hit or the bottom");

    // reads are issued only from idle (top) or while searching (next)
    a_read_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cmd.rd_next || r_state == S_SRCH) && (!cmd.rd_top || accept))
        else $error("memory read issued from the wrong state");

endmodule

### src/bss_dp.sv
// ============================================================================
// bss_dp
// Stack datapath: entry RAM, fill count, search pointer, result register.
// ============================================================================
module bss_dp
    import bss_pkg::*;
#(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CAP_W-1:0]    i_cfg_wdata,
    input  logic [VALUE_W-1:0]  i_value,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic [VALUE_W-1:0]  o_read_value,
    output logic [DIST_W-1:0]   o_distance_from_top,
    output logic                o_is_empty
);

    localparam int AW     = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [CAP_W-1:0]      r_cap;
    logic [AW-1:0]         r_ptr;
    logic [DIST_W-1:0]     r_dist;
    logic [VALUE_BITS-1:0] r_key;
    logic [STATUS_W-1:0]   r_status;
    logic [VALUE_W-1:0]    r_read_value;
    logic [DIST_W-1:0]     r_distance;
    logic                  r_is_empty;

    logic [FILL_W-1:0]     fill_m1;
    logic [AW-1:0]         raddr;
    logic                  re;
    logic [VALUE_BITS-1:0] rdata;

    assign fill_m1 = r_fill - FILL_W'(1);
    assign re      = i_cmd.rd_top || i_cmd.rd_next;
    assign raddr   = i_cmd.rd_top ? fill_m1[AW-1:0] : r_ptr - AW'(1);

    // capacity above the depth saturates: the fill-count limit takes over
    assign o_sts.full  = (CMP_W'(r_fill) >= CMP_W'(r_cap)) || (r_fill >= FILL_MAX);
    assign o_sts.empty = (r_fill == '0);
    assign o_sts.hit   = (rdata == r_key);
    assign o_sts.last  = (r_ptr == '0);

    always_comb begin
        if (i_cmd.push_wr) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_cmd.pop_dec) begin
            n_fill = fill_m1;
        end else begin
            n_fill = r_fill;
        end
    end

    bss_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push_wr),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_value[VALUE_BITS-1:0]),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cap  <= CAP_RESET;
        end else begin
            r_fill <= n_fill;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_value[VALUE_BITS-1:0];
        end
        if (re) begin
            r_ptr <= raddr;
        end
        if (i_cmd.accept) begin
            r_dist <= '0;
        end else if (i_cmd.rd_next) begin
            r_dist <= r_dist + DIST_W'(1);   // wraps: low bits only
        end
        if (i_cmd.res_load) begin
            r_status     <= i_cmd.res_status;
            r_read_value <= i_cmd.res_use_rd ? VALUE_W'(rdata) : '0;
            r_distance   <= i_cmd.res_use_dist ? r_dist : '0;
            r_is_empty   <= (n_fill == '0);
        end
    end

    assign o_status            = r_status;
    assign o_read_value        = r_read_value;
    assign o_distance_from_top = r_distance;
    assign o_is_empty          = r_is_empty;

endmodule

### src/bounded_stack_with_search_unit.sv
// ============================================================================
// bounded_stack_with_search_unit
// Bounded LIFO stack in RAM with push, pop, peek and top-down search.
// ============================================================================
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  ---------------------------------------
//  i_req     in   valid/ready        action[1:0], value[63:0]
//  o_rsp     out  valid/ready        status[1:0], read_value[63:0],
//                                    distance_from_top[7:0], is_empty
//  i_cfg_*   in   write enable only  capacity[8:0]
//
//  Push and any refused request load the result as they are taken; pop
//  and peek read the top entry first; a search ends on a hit or the bottom.
//  Reads go through the single read port of the entry RAM, walked
//  one entry per cycle from the top.
//  Reset (synchronous, active low) clears the fill count and sets the
//  capacity to 256; the RAM is not cleared, since only pushed entries are
//  ever read.
//  A stalled result is held in the output register; the next item is taken
//  in the cycle the result is taken, and a finishing read waits for it.
// ============================================================================
module bounded_stack_with_search_unit
    import bss_pkg::*;
#(
    parameter int DEPTH      = 256,   // entry RAM depth, 2..65536
    parameter int VALUE_BITS = 64     // stored and compared value bits, 1..64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    bss_req_if.sink          i_req,
    bss_rsp_if.source        o_rsp
);

    t_cmd cmd;   // sequencer commands into the datapath
    t_sts sts;   // fill / compare status back to the sequencer

    // Sequencer: owns the handshakes and the result-valid flag.
    bss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_action    (i_req.action),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: RAM, counters, compare and the result payload register.
    bss_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_value             (i_req.value),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_status            (o_rsp.status),
        .o_read_value        (o_rsp.read_value),
        .o_distance_from_top (o_rsp.distance_from_top),
        .o_is_empty          (o_rsp.is_empty)
    );

endmodule
